### sv/tgu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgu_pkg
// Shared widths, types and constants of the tetrahedron geometry unit.
// ----------------------------------------------------------------------------
package tgu_pkg;

  localparam int CW    = 24;
  localparam int FB    = 16;
  localparam int DW    = CW + 1;
  localparam int CXW   = 2 * DW;
  localparam int SQW   = 2 * DW;
  localparam int LW    = 4 * DW;
  localparam int DETW  = 3 * DW + 1;
  localparam int MAGW  = 3 * DW;
  localparam int DVW   = 2 * MAGW + 2;
  localparam int PW    = 2 * LW + 2;
  localparam int OUTW  = 48;
  localparam int QW    = 2 * OUTW;
  localparam int DIVW  = (PW > DVW + QW) ? PW : DVW + QW;
  localparam int RTW   = QW + 2;
  localparam int MULW  = LW + 1;
  localparam int MLW   = 32;
  localparam int MN    = (MULW + MLW - 1) / MLW;
  localparam int MPW   = MN * MLW;
  localparam int QD    = 4;
  localparam int QAW   = $clog2(QD);
  localparam int NDIG  = 4;
  localparam int NV    = (MAGW - 1 + NDIG - 1) / NDIG;
  localparam int VW    = NV * NDIG;
  localparam int VOL_LSB = 2 * FB;
  localparam int VOL_TOP = VOL_LSB + OUTW;
  localparam int VXW   = ((VW > VOL_TOP) ? VW : VOL_TOP) + 1;

  localparam logic [OUTW-1:0] OUT_MAX = '1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef diff_t [2:0] vec_t;
  typedef logic [OUTW-1:0] out_t;

  typedef struct packed {
    vec_t u;
    vec_t v;
    vec_t w;
    vec_t e12;
    vec_t e13;
    vec_t e23;
  } edges_t;

endpackage
`default_nettype wire

### sv/tgu_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgu_in_if
// Request channel: the four vertices of one tetrahedron.
// ----------------------------------------------------------------------------
interface tgu_in_if;
  import tgu_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vertex0_x;
  coord_t vertex0_y;
  coord_t vertex0_z;
  coord_t vertex1_x;
  coord_t vertex1_y;
  coord_t vertex1_z;
  coord_t vertex2_x;
  coord_t vertex2_y;
  coord_t vertex2_z;
  coord_t vertex3_x;
  coord_t vertex3_y;
  coord_t vertex3_z;

  modport source (
    output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
    vertex2_x, vertex2_y, vertex2_z, vertex3_x, vertex3_y, vertex3_z,
    input  ready
  );
  modport sink (
    input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
    vertex2_x, vertex2_y, vertex2_z, vertex3_x, vertex3_y, vertex3_z,
    output ready
  );
endinterface
`default_nettype wire

### sv/tgu_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgu_out_if
// Result channel: orientation, volume, circumscribed diameter, degenerate.
// ----------------------------------------------------------------------------
interface tgu_out_if;
  import tgu_pkg::*;

  logic valid;
  logic ready;
  logic right_handed;
  out_t tet_volume;
  out_t circum_diameter;
  logic degenerate;

  modport source (
    output valid, right_handed, tet_volume, circum_diameter, degenerate,
    input  ready
  );
  modport sink (
    input  valid, right_handed, tet_volume, circum_diameter, degenerate,
    output ready
  );
endinterface
`default_nettype wire

### sv/tgu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgu_queue
// Short queue of edge records between the front and the back.
// ----------------------------------------------------------------------------
module tgu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tgu_pkg::edges_t wdata,
  output logic            full,
  input  logic            pop,
  output tgu_pkg::edges_t rdata,
  output logic            empty
);
  import tgu_pkg::*;

  edges_t         mem [QD];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = count == (QAW+1)'(QD);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### sv/tgu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgu_front
// Accepts requests; forms edges u, v, w, e12, e13, e23 of each tetrahedron.
// ----------------------------------------------------------------------------
module tgu_front (
  input  logic            clk,
  input  logic            rst,
  tgu_in_if.sink          req,
  input  logic            q_full,
  output logic            q_push,
  output tgu_pkg::edges_t q_data
);
  import tgu_pkg::*;

  logic   f_valid;
  edges_t f_edges;
  edges_t edges_next;
  diff_t  pt [4][3];

  always_comb begin
    pt[0][0] = diff_t'(req.vertex0_x);
    pt[0][1] = diff_t'(req.vertex0_y);
    pt[0][2] = diff_t'(req.vertex0_z);
    pt[1][0] = diff_t'(req.vertex1_x);
    pt[1][1] = diff_t'(req.vertex1_y);
    pt[1][2] = diff_t'(req.vertex1_z);
    pt[2][0] = diff_t'(req.vertex2_x);
    pt[2][1] = diff_t'(req.vertex2_y);
    pt[2][2] = diff_t'(req.vertex2_z);
    pt[3][0] = diff_t'(req.vertex3_x);
    pt[3][1] = diff_t'(req.vertex3_y);
    pt[3][2] = diff_t'(req.vertex3_z);
    for (int k = 0; k < 3; k++) begin
      edges_next.u[k]   = pt[1][k] - pt[0][k];
      edges_next.v[k]   = pt[2][k] - pt[0][k];
      edges_next.w[k]   = pt[3][k] - pt[0][k];
      edges_next.e12[k] = pt[2][k] - pt[1][k];
      edges_next.e13[k] = pt[3][k] - pt[1][k];
      edges_next.e23[k] = pt[3][k] - pt[2][k];
    end
  end

  assign req.ready = !f_valid || !q_full;
  assign q_push    = f_valid && !q_full;
  assign q_data    = f_edges;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      f_edges <= edges_next;
    end
  end

endmodule
`default_nettype wire

### sv/tgu_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgu_mul
// Wide unsigned multiplier: 32x32 partial products, row sums, final sum.
// Three stages, advanced by en.
// ----------------------------------------------------------------------------
module tgu_mul (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tgu_pkg::MULW-1:0]   a,
  input  logic [tgu_pkg::MULW-1:0]   b,
  output logic [2*tgu_pkg::MPW-1:0]  p
);
  import tgu_pkg::*;

  logic [MPW-1:0]     ax;
  logic [MPW-1:0]     bx;
  logic [2*MLW-1:0]   pp [MN][MN];
  logic [MPW+MLW-1:0] row [MN];
  logic [MPW+MLW-1:0] row_next [MN];
  logic [2*MPW-1:0]   p_next;

  assign ax = MPW'(a);
  assign bx = MPW'(b);

  always_comb begin
    for (int i = 0; i < MN; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < MN; j++) begin
        row_next[i] = row_next[i] + ((MPW+MLW)'(pp[i][j]) << (j * MLW));
      end
    end
    p_next = '0;
    for (int i = 0; i < MN; i++) begin
      p_next = p_next + ((2*MPW)'(row[i]) << (i * MLW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < MN; i++) begin
        for (int j = 0; j < MN; j++) begin
          pp[i][j] <= (2*MLW)'(ax[i*MLW +: MLW]) * (2*MLW)'(bx[j*MLW +: MLW]);
        end
      end
      row <= row_next;
      p   <= p_next;
    end
  end

endmodule
`default_nettype wire

### sv/tgu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgu_back
// Arithmetic pipeline: triple product, edge-length products, Heron term,
// restoring divide, bitwise square root, divide by six, result register.
// ----------------------------------------------------------------------------
module tgu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  tgu_pkg::edges_t q_data,
  output logic            q_pop,
  tgu_out_if.source       res
);
  import tgu_pkg::*;

  localparam int ML = 3;

  logic adv;
  logic res_valid;

  assign adv       = !res_valid || res.ready;
  assign q_pop     = adv && !q_empty;
  assign res.valid = res_valid;

  // products
  vec_t                   ed [6];
  logic                   v1;
  logic signed [CXW-1:0]  s1_cp [6];
  logic signed [CXW-1:0]  s1_sq [6][3];
  vec_t                   s1_w;

  always_comb begin
    ed[0] = q_data.u;
    ed[1] = q_data.v;
    ed[2] = q_data.w;
    ed[3] = q_data.e12;
    ed[4] = q_data.e13;
    ed[5] = q_data.e23;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cp[0] <= $signed(q_data.u[1]) * $signed(q_data.v[2]);
      s1_cp[1] <= $signed(q_data.u[2]) * $signed(q_data.v[1]);
      s1_cp[2] <= $signed(q_data.u[2]) * $signed(q_data.v[0]);
      s1_cp[3] <= $signed(q_data.u[0]) * $signed(q_data.v[2]);
      s1_cp[4] <= $signed(q_data.u[0]) * $signed(q_data.v[1]);
      s1_cp[5] <= $signed(q_data.u[1]) * $signed(q_data.v[0]);
      for (int i = 0; i < 6; i++) begin
        for (int k = 0; k < 3; k++) begin
          s1_sq[i][k] <= $signed(ed[i][k]) * $signed(ed[i][k]);
        end
      end
      s1_w <= q_data.w;
    end
  end

  // cross product and squared edge lengths
  logic                  v2;
  logic signed [CXW-1:0] s2_c [3];
  logic [SQW-1:0]        s2_sq [6];
  vec_t                  s2_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_c[0] <= s1_cp[0] - s1_cp[1];
      s2_c[1] <= s1_cp[2] - s1_cp[3];
      s2_c[2] <= s1_cp[4] - s1_cp[5];
      for (int i = 0; i < 6; i++) begin
        s2_sq[i] <= $unsigned(s1_sq[i][0]) + $unsigned(s1_sq[i][1])
                  + $unsigned(s1_sq[i][2]);
      end
      s2_w <= s1_w;
    end
  end

  // partial products of the dot product and of the squared lengths of opposite edges
  logic                   v3;
  logic signed [2*DW:0]   s3_dl [3];
  logic signed [2*DW-1:0] s3_dh [3];
  logic [2*DW-1:0]        s3_pll [3];
  logic [2*DW-1:0]        s3_plh [3];
  logic [2*DW-1:0]        s3_phl [3];
  logic [2*DW-1:0]        s3_phh [3];
  logic [SQW-1:0]         sa [3];
  logic [SQW-1:0]         sb [3];

  always_comb begin
    sa[0] = s2_sq[3];
    sb[0] = s2_sq[2];
    sa[1] = s2_sq[1];
    sb[1] = s2_sq[4];
    sa[2] = s2_sq[0];
    sb[2] = s2_sq[5];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s3_dl[k] <= $signed({1'b0, s2_c[k][DW-1:0]}) * $signed(s2_w[k]);
        s3_dh[k] <= $signed(s2_c[k][CXW-1:DW]) * $signed(s2_w[k]);
      end
      for (int i = 0; i < 3; i++) begin
        s3_pll[i] <= (2*DW)'(sa[i][DW-1:0]) * (2*DW)'(sb[i][DW-1:0]);
        s3_plh[i] <= (2*DW)'(sa[i][DW-1:0]) * (2*DW)'(sb[i][SQW-1:DW]);
        s3_phl[i] <= (2*DW)'(sa[i][SQW-1:DW]) * (2*DW)'(sb[i][DW-1:0]);
        s3_phh[i] <= (2*DW)'(sa[i][SQW-1:DW]) * (2*DW)'(sb[i][SQW-1:DW]);
      end
    end
  end

  // combine partial products
  logic                   v4;
  logic signed [DETW-1:0] s4_d [3];
  logic [LW-1:0]          s4_l [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s4_d[k] <= (DETW'(s3_dh[k]) <<< DW) + DETW'(s3_dl[k]);
      end
      for (int i = 0; i < 3; i++) begin
        s4_l[i] <= {s3_phh[i], s3_pll[i]} + ((LW'(s3_plh[i]) + LW'(s3_phl[i])) << DW);
      end
    end
  end

  // triple product
  logic                   v5;
  logic signed [DETW-1:0] s5_det;
  logic [LW-1:0]          s5_l [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_det <= s4_d[0] + s4_d[1] + s4_d[2];
      s5_l   <= s4_l;
    end
  end

  // sign, magnitude, Heron middle term
  logic                   v6;
  logic                   s6_neg;
  logic                   s6_deg;
  logic [MAGW-1:0]        s6_mag;
  logic [LW-1:0]          s6_l [2];
  logic [LW:0]            s6_dm;
  logic signed [DETW-1:0] absd;
  logic signed [LW+1:0]   dd;
  logic [LW+1:0]          dda;

  always_comb begin
    absd = s5_det[DETW-1] ? -s5_det : s5_det;
    dd   = $signed({2'b00, s5_l[0]}) + $signed({2'b00, s5_l[1]})
         - $signed({2'b00, s5_l[2]});
    dda  = dd[LW+1] ? -dd : dd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_neg  <= s5_det[DETW-1];
      s6_deg  <= s5_det == '0;
      s6_mag  <= absd[MAGW-1:0];
      s6_l[0] <= s5_l[0];
      s6_l[1] <= s5_l[1];
      s6_dm   <= dda[LW:0];
    end
  end

  // wide products
  logic [2*MPW-1:0] p12;
  logic [2*MPW-1:0] pd;
  logic [2*MPW-1:0] pm;

  tgu_mul u_mul_l12 (
    .clk (clk),
    .en  (adv),
    .a   (MULW'(s6_l[0])),
    .b   (MULW'(s6_l[1])),
    .p   (p12)
  );

  tgu_mul u_mul_d (
    .clk (clk),
    .en  (adv),
    .a   (MULW'(s6_dm)),
    .b   (MULW'(s6_dm)),
    .p   (pd)
  );

  tgu_mul u_mul_det (
    .clk (clk),
    .en  (adv),
    .a   (MULW'(s6_mag)),
    .b   (MULW'(s6_mag)),
    .p   (pm)
  );

  logic            m_v   [ML];
  logic            m_neg [ML];
  logic            m_deg [ML];
  logic [MAGW-1:0] m_mag [ML];

  always_ff @(posedge clk) begin
    if (adv) begin
      m_neg[0] <= s6_neg;
      m_deg[0] <= s6_deg;
      m_mag[0] <= s6_mag;
      for (int i = 1; i < ML; i++) begin
        m_neg[i] <= m_neg[i-1];
        m_deg[i] <= m_deg[i-1];
        m_mag[i] <= m_mag[i-1];
      end
    end
  end

  // Heron product and divisor
  logic            v7;
  logic [PW-1:0]   p4;
  logic [PW-1:0]   d2;
  logic [PW-1:0]   s7_pp;
  logic [DVW-1:0]  s7_dv;
  logic            s7_neg;
  logic            s7_deg;
  logic [MAGW-1:0] s7_mag;

  assign p4 = {p12[PW-3:0], 2'b00};
  assign d2 = pd[PW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_pp  <= (p4 < d2) ? '0 : p4 - d2;
      s7_dv  <= {pm[DVW-3:0], 2'b00};
      s7_neg <= m_neg[ML-1];
      s7_deg <= m_deg[ML-1];
      s7_mag <= m_mag[ML-1];
    end
  end

  // restoring divide, with the divide by six riding along
  logic            d_v   [QW+1];
  logic [DIVW-1:0] d_rem [QW+1];
  logic [DVW-1:0]  d_dv  [QW+1];
  logic [QW-1:0]   d_q   [QW+1];
  logic [VW-1:0]   d_vx  [QW+1];
  logic [1:0]      d_vr  [QW+1];
  logic            d_neg [QW+1];
  logic            d_deg [QW+1];
  logic            d_big [QW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rem[0] <= DIVW'(s7_pp);
      d_dv[0]  <= s7_dv;
      d_q[0]   <= '0;
      d_vx[0]  <= VW'(s7_mag >> 1);
      d_vr[0]  <= '0;
      d_neg[0] <= s7_neg;
      d_deg[0] <= s7_deg;
      d_big[0] <= DIVW'(s7_pp) >= (DIVW'(s7_dv) << QW);
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic [DIVW-1:0] trial;
    logic            ge;
    logic [VW-1:0]   vx_next;
    logic [1:0]      vr_next;

    assign trial = DIVW'(d_dv[s]) << K;
    assign ge    = d_rem[s] >= trial;

    if (s < NV) begin : g_dig
      logic [5:0]  x;
      logic [11:0] prod;
      logic [3:0]  qd;
      logic [5:0]  rm;
      always_comb begin
        x       = {d_vr[s], d_vx[s][NDIG*(NV-1-s) +: NDIG]};
        prod    = 12'(x) * 12'd43;
        qd      = prod[10:7];
        rm      = x - 6'(qd) * 6'd3;
        vx_next = d_vx[s];
        vx_next[NDIG*(NV-1-s) +: NDIG] = qd;
        vr_next = rm[1:0];
      end
    end else begin : g_pass
      assign vx_next = d_vx[s];
      assign vr_next = d_vr[s];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_rem[s+1] <= ge ? d_rem[s] - trial : d_rem[s];
        d_q[s+1]   <= d_q[s] | (ge ? (QW'(1) << K) : '0);
        d_dv[s+1]  <= d_dv[s];
        d_vx[s+1]  <= vx_next;
        d_vr[s+1]  <= vr_next;
        d_neg[s+1] <= d_neg[s];
        d_deg[s+1] <= d_deg[s];
        d_big[s+1] <= d_big[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[s+1] <= 1'b0;
      end else if (adv) begin
        d_v[s+1] <= d_v[s];
      end
    end
  end

  // square root, one result bit per stage
  logic            r_v    [OUTW+1];
  logic [RTW-1:0]  r_rem  [OUTW+1];
  logic [OUTW-1:0] r_root [OUTW+1];
  out_t            r_vol  [OUTW+1];
  logic            r_neg  [OUTW+1];
  logic            r_deg  [OUTW+1];
  logic            r_big  [OUTW+1];
  logic [VXW-1:0]  vxe;

  assign vxe = VXW'(d_vx[QW]);

  always_ff @(posedge clk) begin
    if (adv) begin
      r_rem[0]  <= RTW'(d_q[QW]);
      r_root[0] <= '0;
      r_vol[0]  <= (|vxe[VXW-1:VOL_TOP]) ? OUT_MAX : vxe[VOL_TOP-1:VOL_LSB];
      r_neg[0]  <= d_neg[QW];
      r_deg[0]  <= d_deg[QW];
      r_big[0]  <= d_big[QW];
    end
  end

  for (genvar j = 0; j < OUTW; j++) begin : g_sqrt
    localparam int K = OUTW - 1 - j;
    logic [RTW-1:0] trial;
    logic           ge;

    assign trial = (RTW'(r_root[j]) << (K + 1)) | (RTW'(1) << (2 * K));
    assign ge    = r_rem[j] >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        r_rem[j+1]  <= ge ? r_rem[j] - trial : r_rem[j];
        r_root[j+1] <= r_root[j] | (ge ? (OUTW'(1) << K) : '0);
        r_vol[j+1]  <= r_vol[j];
        r_neg[j+1]  <= r_neg[j];
        r_deg[j+1]  <= r_deg[j];
        r_big[j+1]  <= r_big[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        r_v[j+1] <= 1'b0;
      end else if (adv) begin
        r_v[j+1] <= r_v[j];
      end
    end
  end

  // valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      d_v[0]    <= 1'b0;
      r_v[0]    <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < ML; i++) begin
        m_v[i] <= 1'b0;
      end
    end else if (adv) begin
      v1        <= !q_empty;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      m_v[0]    <= v6;
      for (int i = 1; i < ML; i++) begin
        m_v[i] <= m_v[i-1];
      end
      v7        <= m_v[ML-1];
      d_v[0]    <= v7;
      r_v[0]    <= d_v[QW];
      res_valid <= r_v[OUTW];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      res.right_handed    <= !r_neg[OUTW];
      res.tet_volume      <= r_vol[OUTW];
      res.circum_diameter <= (r_deg[OUTW] || r_big[OUTW]) ? OUT_MAX : r_root[OUTW];
      res.degenerate      <= r_deg[OUTW];
    end
  end

endmodule
`default_nettype wire

### sv/tetrahedron_geometry_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tetrahedron_geometry_unit
// Orientation, volume and circumscribed diameter of a tetrahedron.
// ----------------------------------------------------------------------------
// Takes one tetrahedron per clock while the result side does not stall, and
// returns one result per request, in order. From request to result lie one
// front register, the queue, six arithmetic stages, three stages of wide
// multiply, the Heron stage, 97 stages of the restoring divider, 49 stages
// of the square root and the result register. The divider and square root
// retire one quotient or root bit per stage, which sets the depth. A
// four-entry queue parts the front from the back, so a stall on the result
// side fills the queue before the request side stalls.
// ----------------------------------------------------------------------------
module tetrahedron_geometry_unit (
  input  logic      clk,
  input  logic      rst,
  tgu_in_if.sink    req,
  tgu_out_if.source res
);
  import tgu_pkg::*;

  logic   q_full;
  logic   q_push;
  logic   q_empty;
  logic   q_pop;
  edges_t q_wdata;
  edges_t q_rdata;

  tgu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  tgu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tgu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
`default_nettype wire

### tb/tgu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgu_checker
// Watches both channels of the tetrahedron geometry unit, computes the
// orientation, volume and circumscribed diameter of every accepted request
// with exact wide integer arithmetic, and compares each result in order.
// ----------------------------------------------------------------------------
module tgu_checker (
  input  logic clk,
  input  logic rst,
  tgu_in_if    req,
  tgu_out_if   res,
  output int   errors,
  output int   pending
);
  import tgu_pkg::*;

  typedef struct packed {
    logic right_handed;
    out_t tet_volume;
    out_t circum_diameter;
    logic degenerate;
  } tet_result_t;

  tet_result_t expected_q[$];

  function automatic logic signed [127:0] mul3(longint a, longint b, longint c);
    logic signed [127:0] x, y, z;
    x = a;
    y = b;
    z = c;
    return x * y * z;
  endfunction

  function automatic logic [127:0] sq_len(longint a[3], longint b[3]);
    logic [127:0] acc;
    longint d;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      d = a[k] - b[k];
      acc += 128'(d * d);
    end
    return acc;
  endfunction

  function automatic tet_result_t tet_geometry(coord_t c[12]);
    longint p[4][3];
    longint u[3], v[3], w[3];
    logic signed [127:0] det;
    logic [127:0] mag, vq, l1, l2, l3, r, t;
    logic [255:0] pp, pn, dv, q;
    tet_result_t o;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) p[i][k] = longint'(c[i*3+k]);
    for (int k = 0; k < 3; k++) begin
      u[k] = p[1][k] - p[0][k];
      v[k] = p[2][k] - p[0][k];
      w[k] = p[3][k] - p[0][k];
    end
    det = mul3(u[1], v[2], w[0]) - mul3(u[2], v[1], w[0]) + mul3(u[2], v[0], w[1])
        - mul3(u[0], v[2], w[1]) + mul3(u[0], v[1], w[2]) - mul3(u[1], v[0], w[2]);
    mag = (det < 0) ? 128'(-det) : 128'(det);
    o.right_handed = !(det < 0);
    o.degenerate = (mag == 0);
    vq = mag / 6;
    o.tet_volume = ((vq >> 32) >> OUTW) != 0 ? OUT_MAX : vq[OUTW+31:32];
    o.circum_diameter = OUT_MAX;
    if (mag != 0) begin
      l1 = sq_len(p[1], p[2]) * sq_len(p[0], p[3]);
      l2 = sq_len(p[0], p[2]) * sq_len(p[1], p[3]);
      l3 = sq_len(p[0], p[1]) * sq_len(p[2], p[3]);
      pp = 2 * (256'(l1) * l2 + 256'(l2) * l3 + 256'(l3) * l1);
      pn = 256'(l1) * l1 + 256'(l2) * l2 + 256'(l3) * l3;
      pp = (pp < pn) ? '0 : pp - pn;
      dv = 4 * (256'(mag) * mag);
      if (pp < (dv << 96)) begin
        q = pp / dv;
        r = '0;
        for (int k = OUTW - 1; k >= 0; k--) begin
          t = r | (128'(1) << k);
          if (256'(t) * t <= q) r = t;
        end
        o.circum_diameter = r[OUTW-1:0];
      end
    end
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    coord_t c[12];
    tet_result_t got, want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (req.valid && req.ready) begin
        c = '{req.vertex0_x, req.vertex0_y, req.vertex0_z, req.vertex1_x,
              req.vertex1_y, req.vertex1_z, req.vertex2_x, req.vertex2_y,
              req.vertex2_z, req.vertex3_x, req.vertex3_y, req.vertex3_z};
        expected_q.push_back(tet_geometry(c));
      end
      if (res.valid && res.ready) begin
        got = '{res.right_handed, res.tet_volume, res.circum_diameter, res.degenerate};
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("result with no request outstanding: %p", got);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch: rh %0b/%0b vol %0d/%0d diam %0d/%0d deg %0b/%0b (exp/act)",
                       want.right_handed, got.right_handed, want.tet_volume,
                       got.tet_volume, want.circum_diameter, got.circum_diameter,
                       want.degenerate, got.degenerate);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

### tb/tetrahedron_geometry_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetrahedron_geometry_unit_tb
// Drives directed and random tetrahedra into the geometry unit with random
// gaps and result-side stalls; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tetrahedron_geometry_unit_tb;
  import tgu_pkg::*;

  typedef coord_t verts_t [12];

  localparam int NUM_RANDOM = 580;
  localparam int CALM_AT    = 500;
  localparam int LIMIT      = 200000;
  localparam int CMIN       = -(1 << (CW - 1));
  localparam int CMAX       = (1 << (CW - 1)) - 1;

  logic clk;
  logic rst;
  logic calm;
  int   errors;
  int   pending;
  int   cycles;

  tgu_in_if  req ();
  tgu_out_if res ();

  tetrahedron_geometry_unit u_dut (.clk(clk), .rst(rst), .req(req), .res(res));
  tgu_checker u_chk (.clk(clk), .rst(rst), .req(req), .res(res),
                     .errors(errors), .pending(pending));

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tetrahedron_geometry_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic send_tet(verts_t c);
    req.valid     <= 1'b1;
    req.vertex0_x <= c[0];
    req.vertex0_y <= c[1];
    req.vertex0_z <= c[2];
    req.vertex1_x <= c[3];
    req.vertex1_y <= c[4];
    req.vertex1_z <= c[5];
    req.vertex2_x <= c[6];
    req.vertex2_y <= c[7];
    req.vertex2_z <= c[8];
    req.vertex3_x <= c[9];
    req.vertex3_y <= c[10];
    req.vertex3_z <= c[11];
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic verts_t make_tet(int lo, int hi, int kind);
    verts_t c;
    int b[3], d1[3], d2[3];
    for (int i = 0; i < 12; i++) c[i] = coord_t'($urandom_range(0, hi - lo) + lo);
    if (kind != 0) begin
      // coplanar fourth vertex, nudged off for kind 2, mixed coords for kind 3
      for (int k = 0; k < 3; k++) begin
        b[k]  = $urandom_range(0, 1 << 21) - (1 << 20);
        d1[k] = $urandom_range(0, 1 << 19) - (1 << 18);
        d2[k] = $urandom_range(0, 1 << 19) - (1 << 18);
        c[k]     = coord_t'(b[k]);
        c[3+k]   = coord_t'(b[k] + d1[k]);
        c[6+k]   = coord_t'(b[k] + d2[k]);
        c[9+k]   = coord_t'(b[k] + d1[k] + d2[k]);
      end
      if (kind == 2) c[9 + $urandom_range(0, 2)] += coord_t'($urandom_range(0, 1) ? 1 : -1);
      if (kind == 3) for (int k = 0; k < 3; k++) c[9+k] = c[$urandom_range(0, 2)*3+k];
    end
    return c;
  endfunction

  initial begin
    rst       = 1'b1;
    calm      = 1'b0;
    cycles    = 0;
    req.valid = 1'b0;
    {req.vertex0_x, req.vertex0_y, req.vertex0_z, req.vertex1_x, req.vertex1_y,
     req.vertex1_z, req.vertex2_x, req.vertex2_y, req.vertex2_z, req.vertex3_x,
     req.vertex3_y, req.vertex3_z} = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_tet('{default: coord_t'(0)});
    send_tet('{0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 65536});
    send_tet('{0, 0, 0, 0, 65536, 0, 65536, 0, 0, 0, 0, 65536});
    send_tet('{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX});
    send_tet('{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN});
    send_tet('{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX});
    send_tet('{default: coord_t'(CMAX)});
    send_tet('{default: coord_t'(CMIN)});
    send_tet('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1});
    send_tet('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, -1});
    send_tet('{CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, 5, 7, 0});
    send_tet('{0, 0, 0, CMAX, 0, 0, 0, CMAX, 0, 0, 0, 1});
    send_tet('{1, 2, 3, 1, 2, 3, 9, 9, 9, -4, 5, 6});
    for (int i = 0; i < 4; i++) send_tet(make_tet(0, 0, 1 + i % 3));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      int sel;
      if (n == CALM_AT) calm <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      if (n == 300) begin
        req.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      sel = $urandom_range(0, 19);
      if (sel < 8)       send_tet(make_tet(CMIN, CMAX, 0));
      else if (sel < 13) send_tet(make_tet(-2000, 2000, 0));
      else if (sel < 15) send_tet(make_tet(-3, 3, 0));
      else if (sel < 18) send_tet(make_tet(0, 0, 2));
      else               send_tet(make_tet(0, 0, sel == 18 ? 1 : 3));
    end
    req.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("tetrahedron_geometry_unit_tb OK");
    else
      $display("tetrahedron_geometry_unit_tb NOT OK");
    $finish;
  end

  initial begin
    res.ready = 1'b1;
    @(negedge rst);
    repeat (100) @(posedge clk);
    // hold off long enough to fill the queue and stall the request side
    res.ready <= 1'b0;
    repeat (600) @(posedge clk);
    res.ready <= 1'b1;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        res.ready <= 1'b1;
      end
      repeat ($urandom_range(0, 7) == 0 ? 60 : $urandom_range(1, 20)) @(posedge clk);
    end
  end
endmodule

### files.f
sv/tgu_pkg.sv
sv/tgu_in_if.sv
sv/tgu_out_if.sv
sv/tgu_queue.sv
sv/tgu_front.sv
sv/tgu_mul.sv
sv/tgu_back.sv
sv/tetrahedron_geometry_unit.sv
tb/tgu_checker.sv
tb/tetrahedron_geometry_unit_tb.sv
